// ===== hw/rtl/vtsc_pkg.sv =====
package vtsc_pkg;

    localparam int BRIGHT_BITS  = 10;
    localparam int CFG_BITS     = 32;
    localparam int INV_BITS     = 16;
    localparam int WAVE_BITS    = 16;
    localparam int LEVEL_BITS   = 11;
    localparam int RAMP_BITS    = 13;
    localparam int FALL_BITS    = 16;
    localparam int RCP_BITS     = 32;
    localparam int RCP_SHIFT    = 42;
    localparam int DIV_STEPS    = 16;

    localparam logic [31:0] BLACK = 32'hFF00_0000;
    localparam logic [LEVEL_BITS-1:0] ONE_Q10 = 11'd1024;

    // register indexes of the configuration port
    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [1:0] REG_INV_START = 2'd2;
    localparam logic [1:0] REG_INV_END   = 2'd3;

    // role of a color channel inside a spectral segment
    localparam logic [1:0] ROLE_ZERO = 2'd0;
    localparam logic [1:0] ROLE_FULL = 2'd1;
    localparam logic [1:0] ROLE_RAMP = 2'd2;

    // wavelengths in Q10.6 nm
    localparam int NM_120 = 120 * 64;
    localparam int NM_240 = 240 * 64;
    localparam int NM_380 = 380 * 64;
    localparam int NM_420 = 420 * 64;
    localparam int NM_440 = 440 * 64;
    localparam int NM_490 = 490 * 64;
    localparam int NM_510 = 510 * 64;
    localparam int NM_580 = 580 * 64;
    localparam int NM_645 = 645 * 64;
    localparam int NM_700 = 700 * 64;
    localparam int NM_780 = 780 * 64;

    // ceil(2^42 / D) with D the segment width, or the falloff divisor, in Q10.6 nm
    localparam longint unsigned RCP_ONE = 64'd1 << RCP_SHIFT;
    localparam logic [RCP_BITS-1:0] RCP_60  = RCP_BITS'((RCP_ONE + 64'd3839) / 64'd3840);
    localparam logic [RCP_BITS-1:0] RCP_50  = RCP_BITS'((RCP_ONE + 64'd3199) / 64'd3200);
    localparam logic [RCP_BITS-1:0] RCP_20  = RCP_BITS'((RCP_ONE + 64'd1279) / 64'd1280);
    localparam logic [RCP_BITS-1:0] RCP_70  = RCP_BITS'((RCP_ONE + 64'd4479) / 64'd4480);
    localparam logic [RCP_BITS-1:0] RCP_65  = RCP_BITS'((RCP_ONE + 64'd4159) / 64'd4160);
    localparam logic [RCP_BITS-1:0] RCP_800 = RCP_BITS'((RCP_ONE + 64'd51199) / 64'd51200);
    localparam logic [RCP_BITS-1:0] RCP_400 = RCP_BITS'((RCP_ONE + 64'd25599) / 64'd25600);

    typedef struct packed {
        logic                   black;
        logic [BRIGHT_BITS-1:0] bright;
    } t_side;

    // largest y in 0..1024 with y^5 <= i^4 << (50 - 4*bits)
    function automatic logic [LEVEL_BITS-1:0] gamma_entry(input int unsigned i,
                                                          input int unsigned bits);
        longint unsigned target;
        longint unsigned ii;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        ii = longint'(i);
        target = (ii * ii * ii * ii) << (50 - 4 * bits);
        lo = 0;
        hi = 1024;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (mid * mid * mid * mid * mid <= target) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return LEVEL_BITS'(lo);
    endfunction

endpackage

// ===== hw/rtl/vtsc_div_stage.sv =====
module vtsc_div_stage
    import vtsc_pkg::*;
#(
    parameter int RW = 49,
    parameter int IW = 33,
    parameter int J  = 15
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [RW-1:0]        i_rem,
    input  logic [IW-1:0]        i_inv,
    input  logic [DIV_STEPS-1:0] i_quo,
    input  t_side                i_side,
    output logic [RW-1:0]        o_rem,
    output logic [IW-1:0]        o_inv,
    output logic [DIV_STEPS-1:0] o_quo,
    output t_side                o_side
);

    logic [RW-1:0]        r_rem;
    logic [IW-1:0]        r_inv;
    logic [DIV_STEPS-1:0] r_quo;
    t_side                r_side;

    logic [RW-1:0] w_sub;
    logic          w_fit;

    assign w_sub = RW'(i_inv) << J;
    assign w_fit = (i_rem >= w_sub);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= w_fit ? (i_rem - w_sub) : i_rem;
            r_inv  <= i_inv;
            r_quo  <= i_quo | (DIV_STEPS'(w_fit) << J);
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_inv  = r_inv;
    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule

// ===== hw/rtl/value_to_spectral_color.sv =====
// Stages: input, products, sum, divider, segment, reciprocal, level, gamma, out.
// Throughput: one sample per cycle; a full stage holds while the next one holds.
// The wavelength divider is 16 stages, one quotient bit each, and sets the latency.
// Reset: synchronous, active low; clears all stage valid bits and loads the range
// registers with 0 / all ones and the wavelength registers with 380 nm / 780 nm.
module value_to_spectral_color
    import vtsc_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = 10,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [BRIGHT_BITS-1:0] i_brightness,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_pixel_argb,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [CFG_BITS-1:0]    i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = SB + INV_BITS;
    localparam int IW    = SB + INV_BITS + 1;
    localparam int RW    = SB + 33;
    localparam int IXW   = GAMMA_TABLE_BITS + 1;
    localparam int SHW   = LEVEL_BITS + GAMMA_TABLE_BITS;
    localparam int ROM_N = (1 << GAMMA_TABLE_BITS) + 1;
    localparam int PCW   = RAMP_BITS + RCP_BITS;
    localparam int PSW   = FALL_BITS + RCP_BITS;

    localparam int ST_IN   = 1;
    localparam int ST_MUL  = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_SEG  = ST_DIV0 + DIV_STEPS;
    localparam int ST_RCP  = ST_SEG + 1;
    localparam int ST_LVL  = ST_RCP + 1;
    localparam int ST_GAM  = ST_LVL + 1;
    localparam int ST_OUT  = ST_GAM + 1;

    localparam logic [SB-1:0] RANGE_MAX_RST = SB'(32'h0000_FFFF);

    typedef logic [LEVEL_BITS-1:0] t_gamma_rom [ROM_N];

    function automatic t_gamma_rom build_gamma();
        t_gamma_rom rom;
        for (int k = 0; k < ROM_N; k++) begin
            rom[k] = gamma_entry(k, GAMMA_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma();

    // configuration
    logic [SB-1:0]       r_range_min;
    logic [SB-1:0]       r_range_max;
    logic [INV_BITS-1:0] r_inv_start;
    logic [INV_BITS-1:0] r_inv_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= '0;
            r_range_max <= RANGE_MAX_RST;
            r_inv_start <= INV_BITS'(44150);
            r_inv_end   <= INV_BITS'(21509);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RANGE_MIN: r_range_min <= i_cfg_data[SB-1:0];
                REG_RANGE_MAX: r_range_max <= i_cfg_data[SB-1:0];
                REG_INV_START: r_inv_start <= i_cfg_data[INV_BITS-1:0];
                REG_INV_END:   r_inv_end   <= i_cfg_data[INV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and load enables
    logic [ST_OUT:1] r_v;
    logic [ST_OUT:1] en;

    always_comb begin
        en[ST_OUT] = !r_v[ST_OUT] || !i_stall;
        for (int k = ST_OUT - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[ST_IN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[ST_IN]) begin
                r_v[ST_IN] <= i_valid;
            end
            for (int k = ST_IN + 1; k <= ST_OUT; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // input stage: range checks and offsets
    logic          r1_black;
    logic [SB-1:0] r1_d;
    logic [SB-1:0] r1_n;
    logic [SB-1:0] r1_dn;
    logic [BRIGHT_BITS-1:0] r1_bright;

    always_ff @(posedge i_clk) begin
        if (en[ST_IN]) begin
            r1_black  <= (r_range_max <= r_range_min) || (i_sample_value < r_range_min)
                         || (i_sample_value > r_range_max);
            r1_d      <= r_range_max - r_range_min;
            r1_n      <= i_sample_value - r_range_min;
            r1_dn     <= r_range_max - i_sample_value;
            r1_bright <= i_brightness;
        end
    end

    // endpoint products
    logic [PW-1:0] r2_pa;
    logic [PW-1:0] r2_pb;
    logic [SB-1:0] r2_d;
    t_side         r2_side;

    always_ff @(posedge i_clk) begin
        if (en[ST_MUL]) begin
            r2_pa   <= PW'(r_inv_start) * PW'(r1_dn);
            r2_pb   <= PW'(r_inv_end) * PW'(r1_n);
            r2_d    <= r1_d;
            r2_side <= '{black: r1_black, bright: r1_bright};
        end
    end

    // interpolated reciprocal, divider setup
    logic [IW-1:0] w_inv;
    logic [RW-1:0] r3_rem;
    logic [IW-1:0] r3_inv;
    t_side         r3_side;

    assign w_inv = IW'(r2_pa) + IW'(r2_pb);

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r3_rem       <= RW'(r2_d) << 30;
            r3_inv       <= w_inv;
            r3_side.bright <= r2_side.bright;
            // quotient would not fit 16 bits: beyond any visible wavelength
            r3_side.black  <= r2_side.black || (w_inv == '0) || ((IW'(r2_d) << 14) >= w_inv);
        end
    end

    // wavelength divider, one quotient bit per stage
    logic [RW-1:0]        rem_s  [DIV_STEPS+1];
    logic [IW-1:0]        inv_s  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] quo_s  [DIV_STEPS+1];
    t_side                side_s [DIV_STEPS+1];

    assign rem_s[0]  = r3_rem;
    assign inv_s[0]  = r3_inv;
    assign quo_s[0]  = '0;
    assign side_s[0] = r3_side;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        vtsc_div_stage #(
            .RW (RW),
            .IW (IW),
            .J  (DIV_STEPS - 1 - g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_load (en[ST_DIV0 + g]),
            .i_rem  (rem_s[g]),
            .i_inv  (inv_s[g]),
            .i_quo  (quo_s[g]),
            .i_side (side_s[g]),
            .o_rem  (rem_s[g+1]),
            .o_inv  (inv_s[g+1]),
            .o_quo  (quo_s[g+1]),
            .o_side (side_s[g+1])
        );
    end

    // segment select and falloff numerator
    logic [WAVE_BITS-1:0] w_l;
    logic [1:0]           w_role [3];
    logic [RAMP_BITS-1:0] w_x;
    logic [RCP_BITS-1:0]  w_mc;
    logic [FALL_BITS-1:0] w_t;
    logic [RCP_BITS-1:0]  w_ms;
    logic                 w_sfull;

    assign w_l = quo_s[DIV_STEPS];

    always_comb begin
        w_role[0] = ROLE_ZERO;
        w_role[1] = ROLE_ZERO;
        w_role[2] = ROLE_ZERO;
        w_x  = '0;
        w_mc = RCP_60;
        if (w_l <= WAVE_BITS'(NM_440)) begin
            w_role[0] = ROLE_RAMP;
            w_role[2] = ROLE_FULL;
            w_x  = RAMP_BITS'(NM_440 - w_l);
            w_mc = RCP_60;
        end else if (w_l <= WAVE_BITS'(NM_490)) begin
            w_role[1] = ROLE_RAMP;
            w_role[2] = ROLE_FULL;
            w_x  = RAMP_BITS'(w_l - NM_440);
            w_mc = RCP_50;
        end else if (w_l <= WAVE_BITS'(NM_510)) begin
            w_role[1] = ROLE_FULL;
            w_role[2] = ROLE_RAMP;
            w_x  = RAMP_BITS'(NM_510 - w_l);
            w_mc = RCP_20;
        end else if (w_l <= WAVE_BITS'(NM_580)) begin
            w_role[0] = ROLE_RAMP;
            w_role[1] = ROLE_FULL;
            w_x  = RAMP_BITS'(w_l - NM_510);
            w_mc = RCP_70;
        end else if (w_l <= WAVE_BITS'(NM_645)) begin
            w_role[0] = ROLE_FULL;
            w_role[1] = ROLE_RAMP;
            w_x  = RAMP_BITS'(NM_645 - w_l);
            w_mc = RCP_65;
        end else begin
            w_role[0] = ROLE_FULL;
        end

        w_sfull = 1'b0;
        if (w_l > WAVE_BITS'(NM_700)) begin
            w_t  = FALL_BITS'(NM_240 + 7 * (NM_780 - w_l));
            w_ms = RCP_800;
        end else if (w_l < WAVE_BITS'(NM_420)) begin
            w_t  = FALL_BITS'(NM_120 + 7 * (w_l - NM_380));
            w_ms = RCP_400;
        end else begin
            w_t     = '0;
            w_ms    = RCP_800;
            w_sfull = 1'b1;
        end
    end

    logic [1:0]           r20_role [3];
    logic [RAMP_BITS-1:0] r20_x;
    logic [RCP_BITS-1:0]  r20_mc;
    logic [FALL_BITS-1:0] r20_t;
    logic [RCP_BITS-1:0]  r20_ms;
    logic                 r20_sfull;
    t_side                r20_side;

    always_ff @(posedge i_clk) begin
        if (en[ST_SEG]) begin
            r20_role  <= w_role;
            r20_x     <= w_x;
            r20_mc    <= w_mc;
            r20_t     <= w_t;
            r20_ms    <= w_ms;
            r20_sfull <= w_sfull;
            r20_side.bright <= side_s[DIV_STEPS].bright;
            r20_side.black  <= side_s[DIV_STEPS].black || (w_l < WAVE_BITS'(NM_380))
                               || (w_l > WAVE_BITS'(NM_780));
        end
    end

    // constant divisions as reciprocal products
    logic [PCW-1:0] r21_pc;
    logic [PSW-1:0] r21_ps;
    logic [1:0]     r21_role [3];
    logic           r21_sfull;
    t_side          r21_side;

    always_ff @(posedge i_clk) begin
        if (en[ST_RCP]) begin
            r21_pc    <= PCW'(r20_x) * PCW'(r20_mc);
            r21_ps    <= PSW'(r20_t) * PSW'(r20_ms);
            r21_role  <= r20_role;
            r21_sfull <= r20_sfull;
            r21_side  <= r20_side;
        end
    end

    // channel levels scaled by falloff, gamma index
    logic [LEVEL_BITS-1:0]   w_ramp;
    logic [LEVEL_BITS-1:0]   w_s;
    logic [LEVEL_BITS-1:0]   w_c   [3];
    logic [2*LEVEL_BITS-1:0] w_cs  [3];
    logic [LEVEL_BITS-1:0]   w_lvl [3];
    logic [IXW-1:0]          w_idx [3];

    // product of the scaled numerator and the reciprocal carries 42 fraction bits;
    // the 1024 factor is folded in, so the shift drops 32 of them
    assign w_ramp = LEVEL_BITS'(r21_pc >> (RCP_SHIFT - 10));
    assign w_s    = r21_sfull ? ONE_Q10 : LEVEL_BITS'(r21_ps >> (RCP_SHIFT - 10));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r21_role[c])
                ROLE_FULL: w_c[c] = ONE_Q10;
                ROLE_RAMP: w_c[c] = w_ramp;
                default:   w_c[c] = '0;
            endcase
            w_cs[c]  = (2*LEVEL_BITS)'(w_c[c]) * (2*LEVEL_BITS)'(w_s);
            w_lvl[c] = LEVEL_BITS'(w_cs[c] >> 10);
            w_idx[c] = IXW'((SHW'(w_lvl[c]) << GAMMA_TABLE_BITS) >> 10);
        end
    end

    logic [IXW-1:0] r22_idx [3];
    t_side          r22_side;

    always_ff @(posedge i_clk) begin
        if (en[ST_LVL]) begin
            r22_idx  <= w_idx;
            r22_side <= r21_side;
        end
    end

    // gamma lookup
    logic [LEVEL_BITS-1:0] r23_y [3];
    t_side                 r23_side;

    always_ff @(posedge i_clk) begin
        if (en[ST_GAM]) begin
            for (int c = 0; c < 3; c++) begin
                r23_y[c] <= GAMMA_ROM[r22_idx[c]];
            end
            r23_side <= r22_side;
        end
    end

    // brightness, scale to a byte, clamp
    localparam int YBW = LEVEL_BITS + BRIGHT_BITS;
    localparam int SCW = YBW + 8;

    logic [YBW-1:0] w_yb  [3];
    logic [SCW-1:0] w_sc  [3];
    logic [7:0]     w_byte [3];
    logic [31:0]    w_pix;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_yb[c]   = YBW'(r23_y[c]) * YBW'(r23_side.bright);
            w_sc[c]   = ((SCW'(w_yb[c]) << 8) - SCW'(w_yb[c])) >> 18;
            w_byte[c] = (w_sc[c] > SCW'(255)) ? 8'hFF : w_sc[c][7:0];
        end
        w_pix = r23_side.black ? BLACK : (BLACK | {8'h00, w_byte[0], w_byte[1], w_byte[2]});
    end

    logic [31:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_pixel <= w_pix;
        end
    end

    assign o_valid      = r_v[ST_OUT];
    assign o_pixel_argb = r_pixel;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_v))
        else $error("input stalled while a pipeline stage is empty");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_v) == $past($countones(r_v))
            + int'($past(i_valid && !o_stall)) - int'($past(o_valid && !i_stall))))
        else $error("pipeline lost or invented a beat");

    a_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_argb[31:24] == 8'hFF))
        else $error("output pixel is not opaque");
`endif

endmodule
